### src/rma_pkg.sv
package rma_pkg;

	localparam int MAX_SAMPLES_DEF = 16;
	localparam int DIST_W = 18;
	localparam int STR_W = 8;
	localparam int COUNT_W = 5;
	localparam int FAIL_W = 8;
	localparam int MED_W = 16;
	localparam int CFG_W = 8;
	localparam int CFG_IDX_W = 1;

	localparam logic [COUNT_W-1:0] TARGET_RESET = COUNT_W'(5);
	localparam logic [FAIL_W-1:0] MAXF_RESET = FAIL_W'(5);
	localparam logic [FAIL_W-1:0] FAIL_SAT = '1;
	localparam logic [MED_W-1:0] MEDIAN_MAX = 16'hFFFF;

	localparam logic [CFG_IDX_W-1:0] REG_TARGET = 1'b0;
	localparam logic [CFG_IDX_W-1:0] REG_MAXF = 1'b1;

	typedef enum logic [1:0] {
		OP_GOOD  = 2'd0,
		OP_FAIL  = 2'd1,
		OP_ABORT = 2'd2,
		OP_NOP   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		STAT_COLLECT = 2'd0,
		STAT_DONE    = 2'd1,
		STAT_PARTIAL = 2'd2,
		STAT_NONE    = 2'd3
	} stat_t;

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DECIDE,
		ST_SHIFT,
		ST_CHECK,
		ST_FIN,
		ST_MED_HI,
		ST_MED_LO,
		ST_EMIT
	} state_t;

	typedef struct packed {
		logic  load;
		logic  fail_inc;
		logic  fail_clr;
		logic  ins_start;
		logic  shift;
		logic  fin_set;
		stat_t fin_code;
		logic  fin_rd;
		logic  med_hi;
		logic  med_calc;
		logic  res_none;
		logic  res_collect;
		logic  emit;
	} cmd_t;

	typedef struct packed {
		op_t  op;
		logic full;
		logic empty;
		logic shift_done;
		logic target_hit;
		logic fail_limit;
		logic out_free;
	} sts_t;

endpackage

### src/ranging_median_aggregator_core.sv
// Collects ranging samples for one partner in a sorted store and reports the median
// when a session ends by sample target, by consecutive failures or by abort. Every
// accepted item gives exactly one result item. Items are handled one at a time. A good
// sample that is not dropped is inserted in place, and the insertion moves one entry per
// cycle through the sample memory, past the held samples above the insertion point; a
// good sample that ends the session then has its median formed, and a sample dropped
// because the store is full skips the insertion. The next item can be accepted once the
// result is loaded into the output register, where it waits while the next item is
// processed; a second finished result waits until the first is taken, and the input
// stalls meanwhile.
module ranging_median_aggregator_core #(
	parameter int MAX_SAMPLES = rma_pkg::MAX_SAMPLES_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [1:0]                        operation,
	input  logic signed [rma_pkg::DIST_W-1:0] distance,
	input  logic signed [rma_pkg::STR_W-1:0]  signal_strength,
	output logic                              out_valid,
	input  logic                              out_ready,
	output logic [1:0]                        status,
	output logic [rma_pkg::MED_W-1:0]         median_distance,
	output logic signed [rma_pkg::STR_W-1:0]  median_strength,
	output logic [rma_pkg::COUNT_W-1:0]       sample_count,
	input  logic                              cfg_we,
	input  logic [rma_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  logic [rma_pkg::CFG_W-1:0]         cfg_data
);

	rma_pkg::cmd_t cmd;
	rma_pkg::sts_t sts;

	rma_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.sts      (sts),
		.cmd      (cmd)
	);

	rma_dpath #(
		.MAX_SAMPLES (MAX_SAMPLES)
	) u_dpath (
		.clk             (clk),
		.arst_n          (arst_n),
		.cmd             (cmd),
		.sts             (sts),
		.operation       (operation),
		.distance        (distance),
		.signal_strength (signal_strength),
		.cfg_we          (cfg_we),
		.cfg_index       (cfg_index),
		.cfg_data        (cfg_data),
		.out_ready       (out_ready),
		.out_valid       (out_valid),
		.status          (status),
		.median_distance (median_distance),
		.median_strength (median_strength),
		.sample_count    (sample_count)
	);

	a_one_item: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_ready) |=> !in_ready)
		else $error("item accepted while another is in progress");

	a_none_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == rma_pkg::STAT_NONE) |->
		(median_distance == '0 && median_strength == '0 && sample_count == '0))
		else $error("empty session result carries data");

	a_collect_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && status == rma_pkg::STAT_COLLECT) |->
		(median_distance == '0 && median_strength == '0))
		else $error("collecting result carries a median");

endmodule

### src/rma_ctrl.sv
module rma_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_ready,
	input  rma_pkg::sts_t sts,
	output rma_pkg::cmd_t cmd
);

	rma_pkg::state_t state_q;
	rma_pkg::state_t state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= rma_pkg::ST_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		cmd = '0;
		in_ready = 1'b0;
		state_d = state_q;
		unique case (state_q)
			rma_pkg::ST_IDLE: begin
				in_ready = 1'b1;
				if (in_valid) begin
					cmd.load = 1'b1;
					state_d = rma_pkg::ST_DECIDE;
				end
			end
			rma_pkg::ST_DECIDE: begin
				unique case (sts.op)
					rma_pkg::OP_ABORT: begin
						cmd.fin_set = 1'b1;
						cmd.fin_code = rma_pkg::STAT_PARTIAL;
						state_d = rma_pkg::ST_FIN;
					end
					rma_pkg::OP_FAIL: begin
						cmd.fail_inc = 1'b1;
						if (sts.fail_limit) begin
							cmd.fin_set = 1'b1;
							cmd.fin_code = rma_pkg::STAT_PARTIAL;
							state_d = rma_pkg::ST_FIN;
						end else begin
							cmd.res_collect = 1'b1;
							state_d = rma_pkg::ST_EMIT;
						end
					end
					rma_pkg::OP_GOOD: begin
						cmd.fail_clr = 1'b1;
						if (!sts.full) begin
							cmd.ins_start = 1'b1;
							state_d = rma_pkg::ST_SHIFT;
						end else begin
							state_d = rma_pkg::ST_CHECK;
						end
					end
					default: begin
						cmd.res_collect = 1'b1;
						state_d = rma_pkg::ST_EMIT;
					end
				endcase
			end
			rma_pkg::ST_SHIFT: begin
				cmd.shift = 1'b1;
				if (sts.shift_done) begin
					state_d = rma_pkg::ST_CHECK;
				end
			end
			rma_pkg::ST_CHECK: begin
				if (sts.target_hit) begin
					cmd.fin_set = 1'b1;
					cmd.fin_code = rma_pkg::STAT_DONE;
					state_d = rma_pkg::ST_FIN;
				end else if (sts.fail_limit) begin
					cmd.fin_set = 1'b1;
					cmd.fin_code = rma_pkg::STAT_PARTIAL;
					state_d = rma_pkg::ST_FIN;
				end else begin
					cmd.res_collect = 1'b1;
					state_d = rma_pkg::ST_EMIT;
				end
			end
			rma_pkg::ST_FIN: begin
				if (sts.empty) begin
					cmd.res_none = 1'b1;
					state_d = rma_pkg::ST_EMIT;
				end else begin
					cmd.fin_rd = 1'b1;
					state_d = rma_pkg::ST_MED_HI;
				end
			end
			rma_pkg::ST_MED_HI: begin
				cmd.med_hi = 1'b1;
				state_d = rma_pkg::ST_MED_LO;
			end
			rma_pkg::ST_MED_LO: begin
				cmd.med_calc = 1'b1;
				state_d = rma_pkg::ST_EMIT;
			end
			rma_pkg::ST_EMIT: begin
				if (sts.out_free) begin
					cmd.emit = 1'b1;
					state_d = rma_pkg::ST_IDLE;
				end
			end
			default: begin
				state_d = rma_pkg::ST_IDLE;
			end
		endcase
	end

endmodule

### src/rma_dpath.sv
module rma_dpath #(
	parameter int MAX_SAMPLES = rma_pkg::MAX_SAMPLES_DEF
) (
	input  logic                                  clk,
	input  logic                                  arst_n,
	input  rma_pkg::cmd_t                         cmd,
	output rma_pkg::sts_t                         sts,
	input  logic [1:0]                            operation,
	input  logic signed [rma_pkg::DIST_W-1:0]     distance,
	input  logic signed [rma_pkg::STR_W-1:0]      signal_strength,
	input  logic                                  cfg_we,
	input  logic [rma_pkg::CFG_IDX_W-1:0]         cfg_index,
	input  logic [rma_pkg::CFG_W-1:0]             cfg_data,
	input  logic                                  out_ready,
	output logic                                  out_valid,
	output logic [1:0]                            status,
	output logic [rma_pkg::MED_W-1:0]             median_distance,
	output logic signed [rma_pkg::STR_W-1:0]      median_strength,
	output logic [rma_pkg::COUNT_W-1:0]           sample_count
);

	localparam int AW = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1;
	localparam int CW = $clog2(MAX_SAMPLES + 1);
	localparam int TW = (CW > rma_pkg::COUNT_W) ? CW : rma_pkg::COUNT_W;
	localparam int DW = rma_pkg::DIST_W;
	localparam int SW = rma_pkg::STR_W;
	localparam int EW = DW + SW;

	typedef logic [EW-1:0] entry_t;

	entry_t                         mem_q [MAX_SAMPLES];
	entry_t                         rd_q;
	entry_t                         hi_q;
	rma_pkg::op_t                   op_q;
	logic signed [DW-1:0]           dist_q;
	logic signed [SW-1:0]           str_q;
	logic [CW-1:0]                  held_q;
	logic [CW-1:0]                  ptr_q;
	logic [rma_pkg::FAIL_W-1:0]     fail_q;
	logic [rma_pkg::COUNT_W-1:0]    target_q;
	logic [rma_pkg::FAIL_W-1:0]     maxf_q;
	rma_pkg::stat_t                 code_q;
	rma_pkg::stat_t                 res_status_q;
	logic [rma_pkg::MED_W-1:0]      res_dist_q;
	logic [SW-1:0]                  res_str_q;
	logic [rma_pkg::COUNT_W-1:0]    res_count_q;
	logic                           out_valid_q;
	rma_pkg::stat_t                 out_status_q;
	logic [rma_pkg::MED_W-1:0]      out_dist_q;
	logic [SW-1:0]                  out_str_q;
	logic [rma_pkg::COUNT_W-1:0]    out_count_q;

	logic                           mem_we;
	logic                           mem_re;
	logic [AW-1:0]                  waddr;
	logic [AW-1:0]                  raddr;
	entry_t                         wdata;
	logic [CW-1:0]                  held_m1;
	logic [CW-1:0]                  ptr_m2;
	logic [CW-1:0]                  half;
	logic [CW-1:0]                  half_m1;
	logic [rma_pkg::FAIL_W-1:0]     fail_inc;
	logic                           shift_done;
	logic [DW:0]                    dsum;
	logic [DW:0]                    dadj;
	logic [SW:0]                    ssum;
	logic [SW:0]                    sadj;
	logic [DW-1:0]                  med_d;
	logic [SW-1:0]                  med_s;
	logic [rma_pkg::MED_W-1:0]      med_clamp;

	assign held_m1 = held_q - CW'(1);
	assign ptr_m2 = ptr_q - CW'(2);
	assign half = held_q >> 1;
	assign half_m1 = half - CW'(1);
	assign fail_inc = (fail_q == rma_pkg::FAIL_SAT) ? fail_q : fail_q + rma_pkg::FAIL_W'(1);
	assign shift_done = (ptr_q == '0) || ($signed(rd_q[EW-1:SW]) <= dist_q);

	always_comb begin
		sts.op = op_q;
		sts.full = (held_q == CW'(MAX_SAMPLES));
		sts.empty = (held_q == '0);
		sts.shift_done = shift_done;
		sts.target_hit = (TW'(held_q) >= TW'(target_q));
		sts.fail_limit = (op_q == rma_pkg::OP_FAIL) ? (fail_inc >= maxf_q) : (maxf_q == '0);
		sts.out_free = !out_valid_q || out_ready;
	end

	always_comb begin
		mem_we = 1'b0;
		mem_re = 1'b0;
		waddr = ptr_q[AW-1:0];
		wdata = rd_q;
		raddr = held_m1[AW-1:0];
		if (cmd.ins_start) begin
			mem_re = 1'b1;
		end
		if (cmd.shift) begin
			mem_we = 1'b1;
			if (shift_done) begin
				wdata = {dist_q, str_q};
			end else begin
				mem_re = 1'b1;
				raddr = ptr_m2[AW-1:0];
			end
		end
		if (cmd.fin_rd) begin
			mem_re = 1'b1;
			raddr = half[AW-1:0];
		end
		if (cmd.med_hi) begin
			mem_re = 1'b1;
			raddr = half_m1[AW-1:0];
		end
	end

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[waddr] <= wdata;
		end
		if (mem_re) begin
			rd_q <= mem_q[raddr];
		end
	end

	// The lower middle entry sits in the read register, the upper one in hi_q.
	always_comb begin
		dsum = {hi_q[EW-1], hi_q[EW-1:SW]} + {rd_q[EW-1], rd_q[EW-1:SW]};
		dadj = dsum + {{DW{1'b0}}, dsum[DW]};
		ssum = {hi_q[SW-1], hi_q[SW-1:0]} + {rd_q[SW-1], rd_q[SW-1:0]};
		sadj = ssum + {{SW{1'b0}}, ssum[SW]};
		if (held_q[0]) begin
			med_d = hi_q[EW-1:SW];
			med_s = hi_q[SW-1:0];
		end else begin
			med_d = dadj[DW:1];
			med_s = sadj[SW:1];
		end
		if (med_d[DW-1]) begin
			med_clamp = '0;
		end else if (|med_d[DW-2:rma_pkg::MED_W]) begin
			med_clamp = rma_pkg::MEDIAN_MAX;
		end else begin
			med_clamp = med_d[rma_pkg::MED_W-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			held_q <= '0;
			fail_q <= '0;
			target_q <= rma_pkg::TARGET_RESET;
			maxf_q <= rma_pkg::MAXF_RESET;
			out_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				unique case (cfg_index)
					rma_pkg::REG_TARGET: target_q <= cfg_data[rma_pkg::COUNT_W-1:0];
					rma_pkg::REG_MAXF:   maxf_q <= cfg_data;
					default: ;
				endcase
			end
			if (cmd.fail_inc) begin
				fail_q <= fail_inc;
			end
			if (cmd.fail_clr) begin
				fail_q <= '0;
			end
			if (cmd.shift && shift_done) begin
				held_q <= held_q + CW'(1);
			end
			if (cmd.res_none || cmd.med_calc) begin
				held_q <= '0;
				fail_q <= '0;
			end
			if (cmd.emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q <= rma_pkg::op_t'(operation);
			dist_q <= distance;
			str_q <= signal_strength;
		end
		if (cmd.ins_start) begin
			ptr_q <= held_q;
		end
		if (cmd.shift && !shift_done) begin
			ptr_q <= ptr_q - CW'(1);
		end
		if (cmd.fin_set) begin
			code_q <= cmd.fin_code;
		end
		if (cmd.med_hi) begin
			hi_q <= rd_q;
		end
		if (cmd.res_collect) begin
			res_status_q <= rma_pkg::STAT_COLLECT;
			res_dist_q <= '0;
			res_str_q <= '0;
			res_count_q <= rma_pkg::COUNT_W'(held_q);
		end
		if (cmd.res_none) begin
			res_status_q <= rma_pkg::STAT_NONE;
			res_dist_q <= '0;
			res_str_q <= '0;
			res_count_q <= '0;
		end
		if (cmd.med_calc) begin
			res_status_q <= code_q;
			res_dist_q <= med_clamp;
			res_str_q <= med_s;
			res_count_q <= rma_pkg::COUNT_W'(held_q);
		end
		if (cmd.emit) begin
			out_status_q <= res_status_q;
			out_dist_q <= res_dist_q;
			out_str_q <= res_str_q;
			out_count_q <= res_count_q;
		end
	end

	assign out_valid = out_valid_q;
	assign status = out_status_q;
	assign median_distance = out_dist_q;
	assign median_strength = out_str_q;
	assign sample_count = out_count_q;

	a_held_bound: assert property (@(posedge clk) disable iff (!arst_n)
		held_q <= CW'(MAX_SAMPLES))
		else $error("held count exceeds capacity");

	a_end_clears: assert property (@(posedge clk) disable iff (!arst_n)
		(cmd.res_none || cmd.med_calc) |=> (held_q == '0 && fail_q == '0))
		else $error("session state not cleared after end");

endmodule
